// ===== sv/kts_pkg.sv =====
// shared types and constants of the keyframe track sampler
package kts_pkg;

    localparam int KEY_W   = 32;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;
    localparam int SEG_W   = 6;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic                    command;
        logic [SLOT_W-1:0]       key_slot;
        logic [KEY_W-1:0]        key_time;
        logic signed [KEY_W-1:0] key_x;
        logic signed [KEY_W-1:0] key_y;
        logic signed [KEY_W-1:0] key_z;
        logic [KEY_W-1:0]        sample_time;
    } kts_in_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] out_x;
        logic signed [KEY_W-1:0] out_y;
        logic signed [KEY_W-1:0] out_z;
        logic [SEG_W-1:0]        segment;
    } kts_out_t;

endpackage

// ===== sv/kts_ram.sv =====
// generic single write port ram with registered read
module kts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/kts_div.sv =====
// restoring divider for the interpolation fraction, one quotient bit per cycle
module kts_div
    import kts_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [KEY_W-1:0]   num,
    input  logic [KEY_W-1:0]   den,
    output logic               done,
    output logic [FRAC_BITS:0] quo
);

    localparam int CW = $clog2(FRAC_BITS + 1);

    logic              run_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [KEY_W:0]    rem_reg;
    logic [KEY_W-1:0]  den_reg;
    logic [FRAC_BITS:0] quo_reg;

    logic           fits;
    logic [KEY_W:0] rem_sub;

    always_comb
    begin
        fits    = rem_reg >= {1'b0, den_reg};
        rem_sub = fits ? (rem_reg - {1'b0, den_reg}) : rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                if (cnt_reg == CW'(FRAC_BITS))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            // remainder stays below the divisor, so the shift never overflows
            rem_reg <= {rem_sub[KEY_W-1:0], 1'b0};
            quo_reg <= {quo_reg[FRAC_BITS-1:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== sv/keyframe_track_sampler_core.sv =====
// keyframe track sampler: key table, segment scan sequencer and blend datapath
//
// A load command writes one key; a sample command runs a segment scan, a
// fraction divide and a blend. The scan starts at the segment found by the
// previous sample and tests one key pair per cycle out of the key time ram,
// once the read pipe has been filled and except while it is refilled after
// the wrap; a scan that finds no pair is then closed. A stale remembered
// segment (key_count lowered since the last sample) is first reduced by
// repeated subtraction. The fraction divider yields one bit per cycle and
// is skipped when both keys of the segment share one time or the time
// falls outside them. The three components then share one multiplier.
// busy is high for the whole sample; result_valid is a one-cycle strobe
// that the receiver must take, since it cannot stall the block.
module keyframe_track_sampler_core
    import kts_pkg::*;
#(
    parameter int MAX_KEYS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  kts_in_t            item,
    output logic               result_valid,
    output kts_out_t           result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int NW = $clog2(MAX_KEYS + 1);
    localparam int SW = (AW > SEG_W) ? AW : SEG_W;
    localparam int FW = FRAC_BITS + 1;
    localparam int PW = FRAC_BITS + 35;
    localparam int VW = 3 * KEY_W;
    localparam logic [FW-1:0] F_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [PW-1:0] RND =
        {{(PW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK0,
        ST_CHKL,
        ST_MODN,
        ST_PAIR,
        ST_LDA,
        ST_CMP,
        ST_RDT1,
        ST_RDT2,
        ST_CHKF,
        ST_DIVW,
        ST_RV1,
        ST_RV2,
        ST_RV3,
        ST_MUL,
        ST_ACC
    } state_t;

    state_t state_reg;

    logic [COUNT_W-1:0]    key_count_reg;
    logic [SEG_W-1:0]      search_start_reg;
    logic                  valid_reg;
    kts_out_t              result_reg;

    logic [KEY_W-1:0]      t_reg;
    logic [NW-1:0]         n_reg;
    logic [SW-1:0]         ss_reg;
    logic [AW-1:0]         j_reg;
    logic [AW-1:0]         cnt_reg;
    logic [AW-1:0]         idx_reg;
    logic [AW-1:0]         j2_reg;
    logic [KEY_W-1:0]      ta_reg;
    logic [KEY_W-1:0]      t1_reg;
    logic [FW-1:0]         f_reg;
    logic [VW-1:0]         va_reg;
    logic signed [KEY_W:0] diff_reg [3];
    logic [1:0]            comp_reg;
    logic signed [PW-1:0]  prod_reg;

    logic                  accept;
    logic                  load_we;
    logic [SW-1:0]         slot_w;
    logic [NW-1:0]         n_clamp;
    logic [AW-1:0]         traddr;
    logic [KEY_W-1:0]      trdata;
    logic [AW-1:0]         vraddr;
    logic [VW-1:0]         vrdata;
    logic [AW-1:0]         j_plus1;
    logic [AW-1:0]         j_plus2;
    logic [AW-1:0]         n_last;
    logic [AW-1:0]         j2_calc;
    logic                  j_at_last;
    logic                  div_start;
    logic                  div_done;
    logic [FW-1:0]         div_quo;
    logic signed [KEY_W:0] diff_sel;
    logic [KEY_W-1:0]      va_sel;
    logic signed [PW-1:0]  prod_next;
    logic signed [PW-1:0]  rounded;
    logic [KEY_W-1:0]      comp_val;

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = ~busy;
    assign accept       = start & ~busy;
    assign slot_w       = SW'(item.key_slot);
    assign load_we      = accept && (item.command == CMD_LOAD)
                          && (32'(item.key_slot) < MAX_KEYS);
    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        if (key_count_reg == '0)
        begin
            n_clamp = NW'(1);
        end
        else if (32'(key_count_reg) > MAX_KEYS)
        begin
            n_clamp = NW'(MAX_KEYS);
        end
        else
        begin
            n_clamp = NW'(key_count_reg);
        end
    end

    always_comb
    begin
        j_plus1   = AW'(32'(j_reg) + 1);
        j_plus2   = AW'(32'(j_reg) + 2);
        n_last    = AW'(32'(n_reg) - 1);
        j_at_last = (j_reg == n_last);
        j2_calc   = (32'(idx_reg) + 1 < 32'(n_reg)) ? AW'(32'(idx_reg) + 1) : idx_reg;
    end

    // read address of the key time ram, issued the cycle before its data
    always_comb
    begin
        case (state_reg)
            ST_IDLE: traddr = '0;
            ST_CHK0: traddr = n_last;
            ST_PAIR: traddr = j_reg;
            ST_LDA:  traddr = j_plus1;
            ST_CMP:  traddr = j_plus2;
            ST_RDT1: traddr = idx_reg;
            ST_RDT2: traddr = j2_reg;
            default: traddr = '0;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_RV2:  vraddr = j2_reg;
            default: vraddr = idx_reg;
        endcase
    end

    kts_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_time_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (slot_w[AW-1:0]),
        .wdata (item.key_time),
        .raddr (traddr),
        .rdata (trdata)
    );

    kts_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_KEYS)
    ) u_value_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (slot_w[AW-1:0]),
        .wdata ({item.key_z, item.key_y, item.key_x}),
        .raddr (vraddr),
        .rdata (vrdata)
    );

    assign div_start = (state_reg == ST_CHKF)
                       && !((trdata == t1_reg) || (t_reg < t1_reg) || (t_reg > trdata));

    kts_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (t_reg - t1_reg),
        .den   (trdata - t1_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // shared multiplier and rounding, one component at a time
    always_comb
    begin
        case (comp_reg)
            2'd0:
            begin
                diff_sel = diff_reg[0];
                va_sel   = va_reg[KEY_W-1:0];
            end
            2'd1:
            begin
                diff_sel = diff_reg[1];
                va_sel   = va_reg[2*KEY_W-1:KEY_W];
            end
            default:
            begin
                diff_sel = diff_reg[2];
                va_sel   = va_reg[3*KEY_W-1:2*KEY_W];
            end
        endcase
        prod_next = diff_sel * $signed({1'b0, f_reg});
        rounded   = (prod_reg + RND) >>> FRAC_BITS;
        comp_val  = va_sel + rounded[KEY_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            key_count_reg    <= COUNT_W'(1);
            search_start_reg <= '0;
            valid_reg        <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                key_count_reg <= cfg_data;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (item.command == CMD_SAMPLE))
                    begin
                        state_reg <= ST_CHK0;
                    end
                end
                ST_CHK0:
                begin
                    state_reg <= (t_reg <= trdata) ? ST_RV1 : ST_CHKL;
                end
                ST_CHKL:
                begin
                    state_reg <= (t_reg < trdata) ? ST_MODN : ST_RDT1;
                end
                ST_MODN:
                begin
                    if (32'(ss_reg) < 32'(n_reg))
                    begin
                        state_reg <= ST_PAIR;
                    end
                end
                ST_PAIR:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_RDT1;
                    end
                    else if (!j_at_last)
                    begin
                        state_reg <= ST_LDA;
                    end
                end
                ST_LDA:
                begin
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    if ((ta_reg <= t_reg) && (t_reg <= trdata))
                    begin
                        state_reg <= ST_RDT1;
                    end
                    else if ((cnt_reg == AW'(1)) || (j_plus1 == n_last))
                    begin
                        state_reg <= ST_PAIR;
                    end
                end
                ST_RDT1:
                begin
                    state_reg <= ST_RDT2;
                end
                ST_RDT2:
                begin
                    state_reg <= ST_CHKF;
                end
                ST_CHKF:
                begin
                    state_reg <= div_start ? ST_DIVW : ST_RV1;
                end
                ST_DIVW:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_RV1;
                    end
                end
                ST_RV1:
                begin
                    state_reg <= ST_RV2;
                end
                ST_RV2:
                begin
                    state_reg <= ST_RV3;
                end
                ST_RV3:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (comp_reg == 2'd2)
                    begin
                        search_start_reg <= SEG_W'(idx_reg);
                        valid_reg        <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                t_reg  <= item.sample_time;
                n_reg  <= n_clamp;
                ss_reg <= SW'(search_start_reg);
            end
            ST_CHK0:
            begin
                // at or before the first key: hold key 0's value
                idx_reg <= '0;
                j2_reg  <= '0;
                f_reg   <= '0;
            end
            ST_CHKL:
            begin
                idx_reg <= n_last;
            end
            ST_MODN:
            begin
                if (32'(ss_reg) >= 32'(n_reg))
                begin
                    ss_reg <= ss_reg - SW'(n_reg);
                end
                else
                begin
                    j_reg   <= ss_reg[AW-1:0];
                    cnt_reg <= n_last;
                end
            end
            ST_PAIR:
            begin
                if (cnt_reg == '0)
                begin
                    idx_reg <= n_last;
                end
                else if (j_at_last)
                begin
                    // last key paired with itself never brackets here
                    cnt_reg <= cnt_reg - 1'b1;
                    j_reg   <= '0;
                end
            end
            ST_LDA:
            begin
                ta_reg <= trdata;
            end
            ST_CMP:
            begin
                if ((ta_reg <= t_reg) && (t_reg <= trdata))
                begin
                    idx_reg <= j_reg;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    j_reg   <= j_plus1;
                    ta_reg  <= trdata;
                end
            end
            ST_RDT1:
            begin
                j2_reg <= j2_calc;
            end
            ST_RDT2:
            begin
                t1_reg <= trdata;
            end
            ST_CHKF:
            begin
                f_reg <= F_ONE;
            end
            ST_DIVW:
            begin
                f_reg <= div_quo;
            end
            ST_RV2:
            begin
                va_reg <= vrdata;
            end
            ST_RV3:
            begin
                diff_reg[0] <= $signed({vrdata[KEY_W-1], vrdata[KEY_W-1:0]})
                               - $signed({va_reg[KEY_W-1], va_reg[KEY_W-1:0]});
                diff_reg[1] <= $signed({vrdata[2*KEY_W-1], vrdata[2*KEY_W-1:KEY_W]})
                               - $signed({va_reg[2*KEY_W-1], va_reg[2*KEY_W-1:KEY_W]});
                diff_reg[2] <= $signed({vrdata[3*KEY_W-1], vrdata[3*KEY_W-1:2*KEY_W]})
                               - $signed({va_reg[3*KEY_W-1], va_reg[3*KEY_W-1:2*KEY_W]});
                comp_reg    <= 2'd0;
            end
            ST_MUL:
            begin
                prod_reg <= prod_next;
            end
            ST_ACC:
            begin
                case (comp_reg)
                    2'd0:    result_reg.out_x <= comp_val;
                    2'd1:    result_reg.out_y <= comp_val;
                    default:
                    begin
                        result_reg.out_z   <= comp_val;
                        result_reg.segment <= SEG_W'(idx_reg);
                    end
                endcase
                comp_reg <= comp_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule
